>>> design/cdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared constants, types and helpers for the captive DNS responder.
// ----------------------------------------------------------------------------
package cdr_pkg;

    localparam int MAX_QUERY_BYTES = 496;
    localparam int POS_W           = $clog2(MAX_QUERY_BYTES + 1);

    localparam int HEADER_BYTES = 12;
    localparam int LABEL_MAX    = 63;
    localparam int ANSWER_BYTES = 16;
    localparam int ANS_IDX_W    = $clog2(ANSWER_BYTES);
    localparam int TAIL_BYTES   = 4;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_LABEL  = 2'd2;
    localparam logic [1:0] PH_TAIL   = 2'd3;

    localparam logic REG_ANSWER_ADDRESS = 1'b0;
    localparam logic REG_ANSWER_TTL     = 1'b1;

    localparam logic [31:0] ANSWER_ADDRESS_RESET = 32'hC0A8_0401;
    localparam logic [31:0] ANSWER_TTL_RESET     = 32'h0000_0000;

    // What the parser decided for one accepted item
    typedef struct packed {
        logic       emit;       // echo this byte
        logic [7:0] echo_byte;  // echoed value after header rewrite
        logic       answer;     // final byte of a good frame: append the record
        logic       drop;       // final byte of a bad or short frame
    } act_t;

    // Header rewrite: flags, answer count of one, authority and additional counts cleared
    function automatic logic [7:0] header_byte(input logic [POS_W-1:0] pos,
                                               input logic [7:0] b);
        logic [7:0] r;
        r = b;
        case (pos)
            POS_W'(2):  r = 8'h81;
            POS_W'(3):  r = 8'h80;
            POS_W'(6):  r = 8'h00;
            POS_W'(7):  r = 8'h01;
            POS_W'(8), POS_W'(9), POS_W'(10), POS_W'(11): r = 8'h00;
            default:    r = b;
        endcase
        return r;
    endfunction

    // Fixed A record: name pointer, type A, class IN, TTL, length 4, address
    function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                               input logic [31:0] ttl,
                                               input logic [31:0] addr);
        logic [7:0] r;
        case (idx)
            ANS_IDX_W'(0):  r = 8'hC0;
            ANS_IDX_W'(1):  r = 8'h0C;
            ANS_IDX_W'(2):  r = 8'h00;
            ANS_IDX_W'(3):  r = 8'h01;
            ANS_IDX_W'(4):  r = 8'h00;
            ANS_IDX_W'(5):  r = 8'h01;
            ANS_IDX_W'(6):  r = ttl[31:24];
            ANS_IDX_W'(7):  r = ttl[23:16];
            ANS_IDX_W'(8):  r = ttl[15:8];
            ANS_IDX_W'(9):  r = ttl[7:0];
            ANS_IDX_W'(10): r = 8'h00;
            ANS_IDX_W'(11): r = 8'h04;
            ANS_IDX_W'(12): r = addr[31:24];
            ANS_IDX_W'(13): r = addr[23:16];
            ANS_IDX_W'(14): r = addr[15:8];
            default:        r = addr[7:0];
        endcase
        return r;
    endfunction

endpackage

>>> design/cdr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_parser
// Walks header, question labels and type/class; decides what each byte yields.
// ----------------------------------------------------------------------------
module cdr_parser
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          end_of_datagram,
    output cdr_pkg::act_t act
);
    import cdr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       phase_reg, phase_next;
    logic [5:0]       label_left_reg, label_left_next;
    logic [2:0]       tail_left_reg, tail_left_next;
    logic             done_reg, done_next;
    logic             bad_reg, bad_next;
    logic             emit;
    logic [7:0]       echo;

    always_comb
    begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        label_left_next = label_left_reg;
        tail_left_next  = tail_left_reg;
        done_next       = done_reg;
        bad_next        = bad_reg;
        emit            = 1'b0;
        echo            = data_byte;

        if (pos_reg < POS_W'(MAX_QUERY_BYTES))
        begin
            if (!bad_reg && !done_reg)
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        echo = header_byte(pos_reg, data_byte);
                        emit = 1'b1;
                        if (pos_reg == POS_W'(HEADER_BYTES - 1))
                            phase_next = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        if (data_byte == 8'd0)
                        begin
                            phase_next     = PH_TAIL;
                            tail_left_next = 3'(TAIL_BYTES);
                            emit           = 1'b1;
                        end
                        else if (data_byte > 8'(LABEL_MAX))
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            label_left_next = data_byte[5:0];
                            phase_next      = PH_LABEL;
                            emit            = 1'b1;
                        end
                    end
                    PH_LABEL:
                    begin
                        emit = 1'b1;
                        if (label_left_reg != 6'd0)
                            label_left_next = label_left_reg - 6'd1;
                        if (label_left_reg <= 6'd1)
                            phase_next = PH_LENGTH;
                    end
                    default:
                    begin
                        emit = 1'b1;
                        if (tail_left_reg != 3'd0)
                            tail_left_next = tail_left_reg - 3'd1;
                        if (tail_left_reg <= 3'd1)
                            done_next = 1'b1;
                    end
                endcase
            end
            pos_next = pos_reg + POS_W'(1);
        end

        act.emit      = emit;
        act.echo_byte = echo;
        act.answer    = end_of_datagram && done_next && !bad_next;
        act.drop      = end_of_datagram && !(done_next && !bad_next);

        // Final byte: return to the start of a frame
        if (end_of_datagram)
        begin
            pos_next        = '0;
            phase_next      = PH_HEADER;
            label_left_next = '0;
            tail_left_next  = '0;
            done_next       = 1'b0;
            bad_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= PH_HEADER;
            label_left_reg <= '0;
            tail_left_reg  <= '0;
            done_reg       <= 1'b0;
            bad_reg        <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            label_left_reg <= label_left_next;
            tail_left_reg  <= tail_left_next;
            done_reg       <= done_next;
            bad_reg        <= bad_next;
        end
    end

    a_bad_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(bad_reg && done_reg))
        else $error("frame both bad and complete");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_QUERY_BYTES))
        else $error("byte position past limit");

    a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LABEL) |-> (label_left_reg != 6'd0))
        else $error("label phase with no bytes left");

endmodule

>>> design/cdr_reply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_reply
// Result register, answer record sequencer and answer configuration registers.
// ----------------------------------------------------------------------------
module cdr_reply
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  cdr_pkg::act_t act,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          drop_reply
);
    import cdr_pkg::*;

    logic [31:0]          addr_reg;
    logic [31:0]          ttl_reg;
    logic                 valid_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 drop_reg;
    logic                 active_reg;
    logic [ANS_IDX_W-1:0] idx_reg;
    logic                 load_ok;
    logic                 take;

    assign load_ok  = !valid_reg || out_ready;
    assign in_ready = load_ok && !active_reg;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ANSWER_ADDRESS_RESET;
            ttl_reg  <= ANSWER_TTL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANSWER_ADDRESS: addr_reg <= cfg_data;
                default:            ttl_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
            idx_reg    <= '0;
            byte_reg   <= '0;
            last_reg   <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else if (take)
        begin
            last_reg <= 1'b0;
            drop_reg <= 1'b0;
            if (act.answer)
            begin
                valid_reg  <= 1'b1;
                active_reg <= 1'b1;
                if (act.emit)
                begin
                    byte_reg <= act.echo_byte;
                    idx_reg  <= '0;
                end
                else
                begin
                    byte_reg <= answer_byte('0, ttl_reg, addr_reg);
                    idx_reg  <= ANS_IDX_W'(1);
                end
            end
            else if (act.drop)
            begin
                valid_reg <= 1'b1;
                byte_reg  <= 8'h00;
                last_reg  <= 1'b1;
                drop_reg  <= 1'b1;
            end
            else
            begin
                valid_reg <= act.emit;
                byte_reg  <= act.echo_byte;
            end
        end
        else if (load_ok)
        begin
            if (active_reg)
            begin
                valid_reg <= 1'b1;
                byte_reg  <= answer_byte(idx_reg, ttl_reg, addr_reg);
                last_reg  <= (idx_reg == ANS_IDX_W'(ANSWER_BYTES - 1));
                drop_reg  <= 1'b0;
                idx_reg   <= idx_reg + ANS_IDX_W'(1);
                if (idx_reg == ANS_IDX_W'(ANSWER_BYTES - 1))
                    active_reg <= 1'b0;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;
    assign drop_reply = drop_reg;

    a_active_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (valid_reg && !in_ready))
        else $error("input taken while answer record drains");

    a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && drop_reg) |-> (last_reg && byte_reg == 8'h00))
        else $error("drop result malformed");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> !active_reg)
        else $error("last result while record still pending");

    a_record_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && load_ok && idx_reg == ANS_IDX_W'(ANSWER_BYTES - 1))
            |=> (valid_reg && last_reg && !drop_reg && !active_reg))
        else $error("record did not close on its final byte");

endmodule

>>> design/captive_dns_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// captive_dns_responder
// Streams a DNS query in, echoes it with a rewritten header up to the end of
// the first question, and on the final byte appends a fixed A record or flags a drop.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  query in | in_valid / in_ready  | data_byte, end_of_datagram
//  reply    | out_valid / out_ready| out_byte, out_last, drop_reply
//  config   | cfg_we (no wait)     | cfg_index, cfg_data
//
//  One query byte is accepted per cycle while in_ready is high; its result,
//  if any, shows on the reply port the next cycle through the result register.
//  A good final byte holds the input while the answer record sequencer
//  drains the record one byte per cycle whenever out_ready is high.
//  Reply stalls back up only through the single result register: input is
//  taken whenever that register is empty or being emptied and no record drains.
//  Reset clears the parser and result register and restores the address
//  and TTL registers to their defaults; no clearing pass is needed.
//
module captive_dns_responder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_datagram,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        drop_reply
);
    import cdr_pkg::*;

    act_t act;
    logic accept;

    // Advance the parser only on an accepted item
    assign accept = in_valid && in_ready;

    cdr_parser u_parser
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .end_of_datagram (end_of_datagram),
        .act             (act)
    );

    // Result register plus record sequencer; it owns the input ready
    cdr_reply u_reply
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .act        (act),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .drop_reply (drop_reply)
    );

endmodule

>>> verif/captive_dns_responder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// captive_dns_responder_tb
// Feeds DNS query frames byte by byte into the responder and checks every
// reply item against an in-bench model of the parser: header rewrite, label
// walk, answer record, drop on bad or short frames and cut points in the question.
// Traffic is bursty on the query side and the reply side stalls in patterns.
// ----------------------------------------------------------------------------
module captive_dns_responder_tb;

    import cdr_pkg::*;

    // Fixed reply fields
    localparam logic [7:0]  FLAGS_HI    = 8'h81;
    localparam logic [7:0]  FLAGS_LO    = 8'h80;
    localparam logic [15:0] NAME_PTR    = 16'hC00C;
    localparam logic [15:0] RR_TYPE_A   = 16'h0001;
    localparam logic [15:0] RR_CLASS_IN = 16'h0001;
    localparam logic [15:0] RDATA_LEN   = 16'h0004;

    localparam int RANDOM_BYTES_PER_PHASE = 45;
    localparam int PHASES                 = 5;
    localparam int MAX_PRINTED            = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } query_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drop;
    } reply_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_we          = 1'b0;
    logic        cfg_index       = 1'b0;
    logic [31:0] cfg_data        = 32'h0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte       = 8'h0;
    logic        end_of_datagram = 1'b0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        drop_reply;

    captive_dns_responder u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .end_of_datagram (end_of_datagram),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .drop_reply      (drop_reply)
    );

    // Stimulus and expectation stores
    query_byte_t query_bytes[$];
    reply_t      expected_reply[$];
    logic [7:0]  frame_buf[$];

    // Parser model state
    logic [31:0] model_addr = ANSWER_ADDRESS_RESET;
    logic [31:0] model_ttl  = ANSWER_TTL_RESET;
    int          q_pos      = 0;
    logic [1:0]  q_phase    = PH_HEADER;
    int          label_left = 0;
    int          tail_left  = 0;
    bit          q_done     = 1'b0;
    bit          q_bad      = 1'b0;

    // Bookkeeping
    int mismatches      = 0;
    int replies_checked = 0;
    int frames_answered = 0;
    int frames_dropped  = 0;
    int bytes_queued    = 0;
    int bytes_taken     = 0;
    int bytes_driven    = 0;
    int settings_run    = 0;

    // Driver and receiver pacing
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          stall_cycle = 0;
    logic [15:0] stall_pat   = 16'hFFFF;
    query_byte_t next_item;
    reply_t      want;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4_000_000;
        $display("Timeout: reply stream did not drain");
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic expect_reply(input logic [7:0] d, input logic l, input logic dr);
        reply_t r;
        r.data = d;
        r.last = l;
        r.drop = dr;
        expected_reply.push_back(r);
    endtask

    // Advance the parser model by one accepted query byte and queue its replies
    task automatic parse_query_byte(input logic [7:0] b, input logic last_in);
        logic         emit;
        logic [7:0]   echo;
        logic [127:0] answer_rr;
        int           i;
        emit = 1'b0;
        echo = b;
        if (q_pos < MAX_QUERY_BYTES)
        begin
            if (!q_bad && !q_done)
            begin
                case (q_phase)
                    PH_HEADER:
                    begin
                        emit = 1'b1;
                        // flags, answer count of one, authority and additional counts cleared
                        case (q_pos)
                            2:             echo = FLAGS_HI;
                            3:             echo = FLAGS_LO;
                            6:             echo = 8'h00;
                            7:             echo = 8'h01;
                            8, 9, 10, 11:  echo = 8'h00;
                            default:       echo = b;
                        endcase
                        if (q_pos + 1 >= HEADER_BYTES)
                            q_phase = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        if (b == 8'h00)
                        begin
                            q_phase   = PH_TAIL;
                            tail_left = TAIL_BYTES;
                            emit      = 1'b1;
                        end
                        else if (b > LABEL_MAX)
                        begin
                            q_bad = 1'b1;
                        end
                        else
                        begin
                            label_left = int'(b);
                            q_phase    = PH_LABEL;
                            emit       = 1'b1;
                        end
                    end
                    PH_LABEL:
                    begin
                        emit = 1'b1;
                        if (label_left > 0)
                            label_left--;
                        if (label_left == 0)
                            q_phase = PH_LENGTH;
                    end
                    default:
                    begin
                        emit = 1'b1;
                        if (tail_left > 0)
                            tail_left--;
                        if (tail_left == 0)
                            q_done = 1'b1;
                    end
                endcase
            end
            q_pos++;
        end

        if (!last_in)
        begin
            if (emit)
                expect_reply(echo, 1'b0, 1'b0);
        end
        else
        begin
            if (q_done && !q_bad)
            begin
                if (emit)
                    expect_reply(echo, 1'b0, 1'b0);
                answer_rr = {NAME_PTR, RR_TYPE_A, RR_CLASS_IN, model_ttl, RDATA_LEN,
                             model_addr};
                for (i = 0; i < ANSWER_BYTES; i++)
                    expect_reply(answer_rr[127 - 8 * i -: 8], i == ANSWER_BYTES - 1, 1'b0);
                frames_answered++;
            end
            else
            begin
                expect_reply(8'h00, 1'b1, 1'b1);
                frames_dropped++;
            end
            q_pos      = 0;
            q_phase    = PH_HEADER;
            label_left = 0;
            tail_left  = 0;
            q_done     = 1'b0;
            q_bad      = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------
    task automatic add_random(input int n);
        repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_label(input int len);
        frame_buf.push_back(8'(len));
        add_random(len);
    endtask

    task automatic add_labels(input int count, input int max_len);
        repeat (count) add_label($urandom_range(1, max_len));
    endtask

    task automatic build_good(input int count, input int max_len, input int trailing);
        add_random(HEADER_BYTES);
        add_labels(count, max_len);
        frame_buf.push_back(8'h00);
        add_random(TAIL_BYTES + trailing);
    endtask

    // Move the frame into the pending queue, end marker on its last byte
    task automatic send_frame();
        query_byte_t qb;
        int          i;
        for (i = 0; i < frame_buf.size(); i++)
        begin
            qb.data = frame_buf[i];
            qb.eod  = (i == frame_buf.size() - 1);
            query_bytes.push_back(qb);
        end
        bytes_queued += frame_buf.size();
        frame_buf.delete();
    endtask

    task automatic directed_frames();
        // all-ones header, root name, type and class
        repeat (HEADER_BYTES) frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00);
        add_random(TAIL_BYTES);
        send_frame();
        // zero header, longest legal label, junk after the question
        repeat (HEADER_BYTES) frame_buf.push_back(8'h00);
        add_label(LABEL_MAX);
        frame_buf.push_back(8'h00);
        add_random(TAIL_BYTES + 3);
        send_frame();
        // label length one past the limit, bytes after it
        add_random(HEADER_BYTES);
        add_label(1);
        frame_buf.push_back(8'(LABEL_MAX + 1));
        add_random(4);
        send_frame();
        // largest length byte, end marker on it
        add_random(HEADER_BYTES);
        frame_buf.push_back(8'hFF);
        send_frame();
        // one-byte frame
        frame_buf.push_back(8'hFF);
        send_frame();
        // header only
        add_random(HEADER_BYTES);
        send_frame();
        // end marker inside type and class
        add_random(HEADER_BYTES);
        frame_buf.push_back(8'h00);
        add_random(2);
        send_frame();
        // end marker on the name terminator
        add_random(HEADER_BYTES);
        add_label(3);
        frame_buf.push_back(8'h00);
        send_frame();
        // good question followed by bytes that would be bad lengths
        build_good(3, 12, 0);
        repeat (6) frame_buf.push_back(8'($urandom_range(LABEL_MAX + 1, 255)));
        send_frame();
    endtask

    // Mostly well-formed queries with random content; some cut, bad or noise
    task automatic random_frame();
        int kind;
        int count;
        int max_len;
        kind    = $urandom_range(0, 19);
        count   = $urandom_range(0, 4);
        max_len = ($urandom_range(0, 7) == 0) ? LABEL_MAX : 12;
        if (kind < 14)
        begin
            build_good(count, max_len, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
        end
        else if (kind < 17)
        begin
            build_good(count, max_len, 0);
            while (frame_buf.size() > $urandom_range(1, frame_buf.size() - 1))
                void'(frame_buf.pop_back());
        end
        else if (kind < 19)
        begin
            add_random(HEADER_BYTES);
            add_labels(count, max_len);
            frame_buf.push_back(8'($urandom_range(LABEL_MAX + 1, 255)));
            add_random($urandom_range(0, 6));
        end
        else
        begin
            add_random($urandom_range(1, 30));
        end
        send_frame();
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Hold until every queued byte is taken and every reply has come back,
    // then let the answer sequencer settle
    task automatic wait_idle();
        while (query_bytes.size() != 0 || in_valid || expected_reply.size() != 0)
            @(posedge clk);
        repeat (ANSWER_BYTES + 4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: new item at the falling edge once the last one is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || bytes_taken != bytes_driven)
            begin
                bytes_driven = bytes_taken;
                if (gap_left != 0 || query_bytes.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
                else
                begin
                    next_item = query_bytes.pop_front();
                    in_valid        <= 1'b1;
                    data_byte       <= next_item.data;
                    end_of_datagram <= next_item.eod;
                    // end of burst: pick the next burst and the gap before it
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end

            // Receiver: a 16-bit ready pattern, redrawn when the stall counter reaches zero
            if (stall_cycle == 0)
            begin
                stall_cycle = 63;
                stall_pat   = 16'($urandom);
                stall_pat   = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (stall_pat | 16'h1111);
            end
            else
            begin
                stall_cycle--;
            end
            out_ready <= stall_pat[4'(stall_cycle % 16)];
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track writes and accepted bytes, check reply items
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ANSWER_ADDRESS: model_addr = cfg_data;
                    REG_ANSWER_TTL:     model_ttl  = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready === 1'b1)
            begin
                parse_query_byte(data_byte, end_of_datagram);
                bytes_taken++;
            end

            if (out_valid === 1'b1 && out_ready)
            begin
                if (expected_reply.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected reply item: byte %02h last %0b drop %0b",
                                              out_byte, out_last, drop_reply));
                end
                else
                begin
                    want = expected_reply.pop_front();
                    replies_checked++;
                    if (out_byte !== want.data || out_last !== want.last ||
                        drop_reply !== want.drop)
                        report_mismatch($sformatf(
                            "reply %0d: got byte %02h last %0b drop %0b, want %02h %0b %0b",
                            replies_checked, out_byte, out_last, drop_reply,
                            want.data, want.last, want.drop));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, then one traffic phase per register setting
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int phase;
        int start_bytes;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++)
        begin
            // phase 0 runs on the reset values, then the extremes, then random
            case (phase)
                1:
                begin
                    write_register(REG_ANSWER_ADDRESS, 32'h0000_0000);
                    write_register(REG_ANSWER_TTL, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_register(REG_ANSWER_ADDRESS, 32'hFFFF_FFFF);
                    write_register(REG_ANSWER_TTL, 32'h0000_0000);
                end
                default:
                begin
                    if (phase != 0)
                    begin
                        write_register(REG_ANSWER_TTL, $urandom);
                        write_register(REG_ANSWER_ADDRESS, $urandom);
                    end
                end
            endcase
            settings_run++;

            if (phase == 0)
                directed_frames();
            start_bytes = bytes_queued;
            while (bytes_queued - start_bytes < RANDOM_BYTES_PER_PHASE)
                random_frame();
            wait_idle();
        end

        $display("Sent %0d query bytes over %0d register settings; checked %0d reply items",
                 bytes_queued, settings_run, replies_checked);
        $display("Frames answered: %0d, frames dropped: %0d", frames_answered, frames_dropped);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
design/cdr_pkg.sv
design/cdr_parser.sv
design/cdr_reply.sv
design/captive_dns_responder.sv
verif/captive_dns_responder_tb.sv
